FILE: rtl/core/lzw_variable_width_decoder_assert.svh
// ----------------------------------------------------------------------------
// LZW decoder assertion macros
// Shared property forms for the port checker of the LZW decoder.
// ----------------------------------------------------------------------------
`ifndef LZW_VARIABLE_WIDTH_DECODER_ASSERT_SVH
`define LZW_VARIABLE_WIDTH_DECODER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LZWD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LZWD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/lzwd_pkg.sv
// ----------------------------------------------------------------------------
// LZW decoder package
// Types and fixed constants shared by the decoder modules.
// ----------------------------------------------------------------------------
package lzwd_pkg;

  localparam int CodeBits   = 12;
  localparam int NfBits     = 13;
  localparam int DepthBits  = 13;
  localparam int StackDepth = 4096;
  localparam int StackAw    = 12;
  localparam int BufBits    = 24;
  localparam int HeldBits   = 5;
  localparam int PhaseBits  = 7;
  localparam int ClearCode  = 256;
  localparam int FirstFree  = 257;
  localparam int MinWidth   = 9;

  typedef enum logic [1:0] {
    OpPush    = 2'd0,
    OpPull    = 2'd1,
    OpRestart = 2'd2,
    OpUnused  = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    StOk        = 4'd0,
    StNeed      = 4'd1,
    StDone      = 4'd2,
    StRefused   = 4'd3,
    StBadFirst  = 4'd4,
    StEnded     = 4'd5,
    StSkip      = 4'd6,
    StUndefined = 4'd7,
    StChain     = 4'd8,
    StOverflow  = 4'd9
  } status_e;

  typedef enum logic [2:0] {
    FsmIdle,
    FsmPop,
    FsmDecode,
    FsmWalk,
    FsmWalkWait
  } state_e;

  typedef enum logic {
    RegOutLen = 1'b0,
    RegInLen  = 1'b1
  } cfg_reg_e;

  // Write request into the dictionary memories.
  typedef struct packed {
    logic                en;
    logic [CodeBits-1:0] addr;
    logic [CodeBits-1:0] prefix;
    logic [7:0]          suffix;
  } dict_wr_t;

endpackage

FILE: rtl/core/lzwd_dict.sv
// ----------------------------------------------------------------------------
// LZW dictionary
// Prefix and suffix memories with one write port and one registered read.
// ----------------------------------------------------------------------------
module lzwd_dict #(
  parameter int DICT_ENTRIES = 4096
) (
  input  logic                           clk_i,
  input  lzwd_pkg::dict_wr_t             wr_i,
  input  logic                           rd_en_i,
  input  logic [lzwd_pkg::CodeBits-1:0]  rd_addr_i,
  output logic [lzwd_pkg::CodeBits-1:0]  rd_prefix_o,
  output logic [7:0]                     rd_suffix_o
);
  import lzwd_pkg::*;

  localparam int Aw = $clog2(DICT_ENTRIES);

  logic [CodeBits-1:0] prefix_mem [DICT_ENTRIES];
  logic [7:0]          suffix_mem [DICT_ENTRIES];

  // New entries are written as codes are added.
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      prefix_mem[wr_i.addr[Aw-1:0]] <= wr_i.prefix;
      suffix_mem[wr_i.addr[Aw-1:0]] <= wr_i.suffix;
    end
  end

  // Chain lookups return in the cycle after the address.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_prefix_o <= prefix_mem[rd_addr_i[Aw-1:0]];
      rd_suffix_o <= suffix_mem[rd_addr_i[Aw-1:0]];
    end
  end

endmodule

FILE: rtl/core/lzw_variable_width_decoder.sv
// ----------------------------------------------------------------------------
// LZW variable width decoder
// Pull-style decoder of LSB-first LZW codes of 9 to 12 bits.
// ----------------------------------------------------------------------------
// Usage: each input beat carries an operation. A push loads one compressed
// byte into a 24-bit bit buffer; a pull returns the next decoded byte or a
// status (need input, finished, or a sticky error); a restart clears all
// decoding state. Every input beat gives exactly one output beat.
// Configuration writes set output_length (index 0) and input_length
// (index 1) and take effect at once.
// Push, restart, finished and already latched error beats reach the output
// register in the cycle after acceptance. A byte already on the decode
// stack first passes one stack memory read in the pop state; a status found
// while decoding passes the decode state. A new code passes the decode state
// and then walks its chain above the literal, where each chain step is one
// read of the dictionary memory followed by a write of the stack memory; a
// clear code adds decode steps that drop its alignment bits. Reset clears
// all control state; the dictionary and stack contents stay undefined until
// written. When the receiver stalls the result waits in the output register
// and no further input beat is taken until it leaves.
// ----------------------------------------------------------------------------
module lzw_variable_width_decoder #(
  parameter int DICT_ENTRIES   = 4096,
  parameter int MAX_CODE_WIDTH = 12,
  parameter int LENGTH_BITS    = 24
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  lzwd_pkg::cfg_reg_e      cfg_index_i,
  input  logic [LENGTH_BITS-1:0]  cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [1:0]              operation_i,
  input  logic [7:0]              data_byte_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [7:0]              out_byte_o,
  output logic                    is_last_o,
  output logic [3:0]              status_o
);
  import lzwd_pkg::*;

  localparam int AvW = LENGTH_BITS + 4;
  localparam logic [NfBits-1:0]    DictLim  = NfBits'(DICT_ENTRIES);
  localparam logic [3:0]           MaxW     = 4'(MAX_CODE_WIDTH);
  localparam logic [DepthBits-1:0] StackLim = DepthBits'(StackDepth);

  // Registers.
  state_e                 state_q, state_d;
  logic                   out_valid_q, out_valid_d;
  logic [7:0]             out_byte_q, out_byte_d;
  logic                   out_last_q, out_last_d;
  status_e                out_status_q, out_status_d;
  logic [LENGTH_BITS-1:0] out_len_q, in_len_q;
  logic [DepthBits-1:0]   depth_q, depth_d;
  logic [BufBits-1:0]     buf_q, buf_d;
  logic [HeldBits-1:0]    held_q, held_d;
  logic [LENGTH_BITS-1:0] taken_q, taken_d;
  logic [3:0]             width_q, width_d;
  logic [NfBits-1:0]      nf_q, nf_d;
  logic [PhaseBits-1:0]   phase_q, phase_d;
  logic [PhaseBits-1:0]   pend_q, pend_d;
  logic [CodeBits-1:0]    prev_q, prev_d;
  logic [7:0]             lead_q, lead_d;
  logic [LENGTH_BITS-1:0] emitted_q, emitted_d;
  logic                   first_q, first_d;
  status_e                err_q, err_d;
  logic [NfBits-1:0]      cur_q, cur_d;
  logic [CodeBits-1:0]    code_q, code_d;

  // Stack memory ports.
  logic [7:0]             stack_mem [StackDepth];
  logic                   stk_we, stk_re;
  logic [StackAw-1:0]     stk_waddr, stk_raddr;
  logic [7:0]             stk_wdata, stk_rdata_q;

  // Dictionary ports.
  dict_wr_t               dict_wr;
  logic                   dict_re;
  logic [CodeBits-1:0]    dict_rprefix;
  logic [7:0]             dict_rsuffix;

  logic                   in_fire;
  logic [AvW-1:0]         rest_bits;

  assign in_ready_o  = (state_q == FsmIdle) && (!out_valid_q || out_ready_i);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign is_last_o   = out_last_q;
  assign status_o    = out_status_q;

  // Bits the stream can still deliver beyond the buffer.
  always_comb begin
    rest_bits = '0;
    if (taken_q < in_len_q) begin
      rest_bits = {4'b0, in_len_q - taken_q} << 3;
    end
  end

  lzwd_dict #(
    .DICT_ENTRIES(DICT_ENTRIES)
  ) u_dict (
    .clk_i      (clk_i),
    .wr_i       (dict_wr),
    .rd_en_i    (dict_re),
    .rd_addr_i  (cur_q[CodeBits-1:0]),
    .rd_prefix_o(dict_rprefix),
    .rd_suffix_o(dict_rsuffix)
  );

  // Decode stack, written while decoding and walking a chain and read on pops.
  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stack_mem[stk_waddr] <= stk_wdata;
    end
    if (stk_re) begin
      stk_rdata_q <= stack_mem[stk_raddr];
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_len_q <= '0;
      in_len_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegOutLen: out_len_q <= cfg_data_i;
        RegInLen:  in_len_q  <= cfg_data_i;
        default:   out_len_q <= out_len_q;
      endcase
    end
  end

  // Next state and datapath.
  always_comb begin
    logic                   fin;
    logic                   emit;
    logic                   latch;
    status_e                fin_st;
    logic [7:0]             fin_byte;
    logic [HeldBits-1:0]    drop;
    logic [PhaseBits-1:0]   align;
    logic [PhaseBits-1:0]   psum;
    logic [PhaseBits-1:0]   skip;
    logic [CodeBits-1:0]    mask;
    logic [CodeBits-1:0]    code;
    logic [AvW-1:0]         avail;
    logic [NfBits-1:0]      nf_inc;
    logic [DepthBits-1:0]   depth_m1;
    logic [LENGTH_BITS-1:0] em1;

    state_d      = state_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_byte_d   = out_byte_q;
    out_last_d   = out_last_q;
    out_status_d = out_status_q;
    depth_d      = depth_q;
    buf_d        = buf_q;
    held_d       = held_q;
    taken_d      = taken_q;
    width_d      = width_q;
    nf_d         = nf_q;
    phase_d      = phase_q;
    pend_d       = pend_q;
    prev_d       = prev_q;
    lead_d       = lead_q;
    emitted_d    = emitted_q;
    first_d      = first_q;
    err_d        = err_q;
    cur_d        = cur_q;
    code_d       = code_q;

    fin      = 1'b0;
    emit     = 1'b0;
    latch    = 1'b0;
    fin_st   = StOk;
    fin_byte = '0;
    drop     = '0;
    avail    = '0;
    align    = {width_q, 3'b0};
    psum     = '0;
    skip     = '0;
    mask     = CodeBits'((NfBits'(1) << width_q) - NfBits'(1));
    code     = buf_q[CodeBits-1:0] & mask;
    nf_inc   = nf_q + NfBits'(1);
    depth_m1 = depth_q - DepthBits'(1);
    em1      = emitted_q + LENGTH_BITS'(1);

    stk_we    = 1'b0;
    stk_waddr = depth_q[StackAw-1:0];
    stk_wdata = dict_rsuffix;
    stk_re    = 1'b0;
    stk_raddr = depth_m1[StackAw-1:0];
    dict_re   = 1'b0;
    dict_wr   = '{en: 1'b0, addr: nf_q[CodeBits-1:0], prefix: prev_q, suffix: cur_q[7:0]};

    unique case (state_q)
      FsmIdle: begin
        if (in_fire) begin
          unique case (op_e'(operation_i))
            OpPush: begin
              fin = 1'b1;
              if (held_q > HeldBits'(16) || taken_q >= in_len_q) begin
                fin_st = StRefused;
              end else begin
                buf_d   = buf_q | ({16'b0, data_byte_i} << held_q);
                held_d  = held_q + HeldBits'(8);
                taken_d = taken_q + LENGTH_BITS'(1);
              end
            end
            OpPull: begin
              priority if (err_q != StOk) begin
                fin    = 1'b1;
                fin_st = err_q;
              end else if (emitted_q >= out_len_q) begin
                fin    = 1'b1;
                fin_st = StDone;
              end else if (depth_q != '0) begin
                stk_re  = 1'b1;
                state_d = FsmPop;
              end else begin
                state_d = FsmDecode;
              end
            end
            OpRestart: begin
              fin       = 1'b1;
              depth_d   = '0;
              buf_d     = '0;
              held_d    = '0;
              taken_d   = '0;
              width_d   = 4'(MinWidth);
              nf_d      = NfBits'(FirstFree);
              phase_d   = '0;
              pend_d    = '0;
              prev_d    = '0;
              lead_d    = '0;
              emitted_d = '0;
              first_d   = 1'b0;
              err_d     = StOk;
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end

      // A byte left on the stack from an earlier code.
      FsmPop: begin
        depth_d  = depth_m1;
        fin      = 1'b1;
        emit     = 1'b1;
        fin_byte = stk_rdata_q;
      end

      FsmDecode: begin
        if (pend_q != '0) begin
          // Drop skipped alignment bits as far as the buffer allows.
          drop   = (pend_q < PhaseBits'(held_q)) ? pend_q[HeldBits-1:0] : held_q;
          buf_d  = buf_q >> drop;
          held_d = held_q - drop;
          pend_d = pend_q - PhaseBits'(drop);
          avail  = rest_bits + AvW'(held_d);
          if (pend_d != '0) begin
            fin = 1'b1;
            if (avail < AvW'(pend_d)) begin
              fin_st = StSkip;
              latch  = 1'b1;
            end else begin
              fin_st = StNeed;
            end
          end
        end else if (held_q < HeldBits'(width_q)) begin
          avail = rest_bits + AvW'(held_q);
          fin   = 1'b1;
          if (avail < AvW'(width_q)) begin
            fin_st = first_q ? StEnded : StBadFirst;
            latch  = 1'b1;
          end else begin
            fin_st = StNeed;
          end
        end else begin
          buf_d  = buf_q >> width_q;
          held_d = held_q - HeldBits'(width_q);
          avail  = rest_bits + AvW'(held_d);
          if (!first_q) begin
            // The first code must be a literal.
            fin = 1'b1;
            if (code[CodeBits-1:8] != '0) begin
              fin_st = StBadFirst;
              latch  = 1'b1;
            end else begin
              prev_d   = code;
              lead_d   = code[7:0];
              first_d  = 1'b1;
              depth_d  = '0;
              emit     = 1'b1;
              fin_byte = code[7:0];
            end
          end else begin
            psum    = phase_q + PhaseBits'(width_q);
            phase_d = (psum >= align) ? psum - align : psum;
            if (code == CodeBits'(ClearCode)) begin
              // Clear: realign to the segment and restart the dictionary.
              skip = (phase_d == '0) ? '0 : align - phase_d;
              if (avail < AvW'(skip)) begin
                fin    = 1'b1;
                fin_st = StSkip;
                latch  = 1'b1;
              end else begin
                width_d = 4'(MinWidth);
                nf_d    = NfBits'(ClearCode);
                phase_d = '0;
                pend_d  = skip;
              end
            end else if ({1'b0, code} > nf_q) begin
              fin    = 1'b1;
              fin_st = StUndefined;
              latch  = 1'b1;
            end else begin
              code_d  = code;
              state_d = FsmWalk;
              if ({1'b0, code} == nf_q) begin
                // Code not yet defined: previous string plus its lead byte.
                stk_we    = 1'b1;
                stk_waddr = '0;
                stk_wdata = lead_q;
                depth_d   = DepthBits'(1);
                cur_d     = {1'b0, prev_q};
              end else begin
                depth_d = '0;
                cur_d   = {1'b0, code};
              end
            end
          end
        end
      end

      FsmWalk: begin
        if (cur_q[NfBits-1:8] != '0) begin
          if (cur_q >= nf_q || cur_q >= DictLim || depth_q >= StackLim) begin
            fin    = 1'b1;
            fin_st = StChain;
            latch  = 1'b1;
          end else begin
            dict_re = 1'b1;
            state_d = FsmWalkWait;
          end
        end else if (depth_q >= StackLim) begin
          fin    = 1'b1;
          fin_st = StOverflow;
          latch  = 1'b1;
        end else begin
          // Literal reached: add the new entry if the dictionary has room and give the lead byte.
          if (nf_q < DictLim) begin
            dict_wr.en = 1'b1;
            nf_d       = nf_inc;
            if (nf_inc >= (NfBits'(1) << width_q) && width_q < MaxW) begin
              width_d = width_q + 4'd1;
              phase_d = '0;
            end
          end
          prev_d   = code_q;
          lead_d   = cur_q[7:0];
          fin      = 1'b1;
          emit     = 1'b1;
          fin_byte = cur_q[7:0];
        end
      end

      // Suffix goes on the stack, the walk continues at the prefix.
      FsmWalkWait: begin
        stk_we  = 1'b1;
        depth_d = depth_q + DepthBits'(1);
        cur_d   = {1'b0, dict_rprefix};
        state_d = FsmWalk;
      end

      default: begin
        state_d = FsmIdle;
      end
    endcase

    // Result beat into the output register.
    if (fin) begin
      state_d      = FsmIdle;
      out_valid_d  = 1'b1;
      out_status_d = fin_st;
      out_byte_d   = emit ? fin_byte : 8'd0;
      out_last_d   = emit && (em1 == out_len_q);
      if (emit) begin
        emitted_d = em1;
        if (em1 >= out_len_q) begin
          depth_d = '0;
        end
      end
      if (latch) begin
        err_d   = fin_st;
        depth_d = '0;
      end
    end
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= FsmIdle;
      out_valid_q  <= 1'b0;
      out_last_q   <= 1'b0;
      out_status_q <= StOk;
      depth_q      <= '0;
      buf_q        <= '0;
      held_q       <= '0;
      taken_q      <= '0;
      width_q      <= 4'(MinWidth);
      nf_q         <= NfBits'(FirstFree);
      phase_q      <= '0;
      pend_q       <= '0;
      prev_q       <= '0;
      lead_q       <= '0;
      emitted_q    <= '0;
      first_q      <= 1'b0;
      err_q        <= StOk;
    end else begin
      state_q      <= state_d;
      out_valid_q  <= out_valid_d;
      out_last_q   <= out_last_d;
      out_status_q <= out_status_d;
      depth_q      <= depth_d;
      buf_q        <= buf_d;
      held_q       <= held_d;
      taken_q      <= taken_d;
      width_q      <= width_d;
      nf_q         <= nf_d;
      phase_q      <= phase_d;
      pend_q       <= pend_d;
      prev_q       <= prev_d;
      lead_q       <= lead_d;
      emitted_q    <= emitted_d;
      first_q      <= first_d;
      err_q        <= err_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
    cur_q      <= cur_d;
    code_q     <= code_d;
  end

endmodule

FILE: rtl/core/lzwd_checker.sv
// ----------------------------------------------------------------------------
// LZW decoder port checker
// Watches the result channel of the decoder over time.
// ----------------------------------------------------------------------------
`include "lzw_variable_width_decoder_assert.svh"

module lzwd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] out_byte_o,
  input logic       is_last_o,
  input logic [3:0] status_o
);
  import lzwd_pkg::*;

  // A stalled result beat keeps its payload.
  `LZWD_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_byte_o) && $stable(status_o) && $stable(is_last_o), "stalled result beat changed")

  // Only a delivered byte carries data or the last flag.
  `LZWD_ASSERT_NOW(a_status_clean, out_valid_o && (status_o != StOk), (out_byte_o == 8'd0) && !is_last_o, "status beat carries data")

  // Status codes stay within the defined set.
  `LZWD_ASSERT_NOW(a_status_range, out_valid_o, status_o <= StOverflow, "status code out of range")

endmodule

bind lzw_variable_width_decoder lzwd_checker u_lzwd_checker (.*);
